[src/led_strip_effect_generator_core_defines.svh]
// Assertion macros shared by the LED strip effect generator RTL.
`ifndef LED_STRIP_EFFECT_GENERATOR_CORE_DEFINES_SVH
`define LED_STRIP_EFFECT_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LSEG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lseg assertion failed");
`define LSEG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lseg assertion failed");
`else
`define LSEG_ASSERT(lbl, prop)
`define LSEG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/lseg_pkg.sv]
// Package with types, codes and the colour wheel of the LED strip effect generator.
package lseg_pkg;

    localparam int COLOUR_W = 24;
    localparam int CNT_W    = 7;
    localparam int STEP_W   = 8;

    localparam logic [2:0] OP_BLANK    = 3'd0;
    localparam logic [2:0] OP_WIPE     = 3'd1;
    localparam logic [2:0] OP_RAINBOW  = 3'd2;
    localparam logic [2:0] OP_CYCLE    = 3'd3;
    localparam logic [2:0] OP_CHASE    = 3'd4;
    localparam logic [2:0] OP_CHASE_RB = 3'd5;
    localparam logic [2:0] OP_NOP      = 3'd6;

    // Status and result of the reciprocal divider (256 / pixel count).
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] quot;
        logic [CNT_W-1:0]  rem;
    } div_res_t;

    // Three-segment colour wheel: red to green to blue and back to red.
    function automatic logic [COLOUR_W-1:0] wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] w3;
        logic [7:0] seg;
        begin
            w = 8'd255 - pos;
            if (w < 8'd85)
            begin
                w3 = 8'(w * 2'd3);
                wheel = {8'd255 - w3, 8'd0, w3};
            end
            else if (w < 8'd170)
            begin
                seg = w - 8'd85;
                w3  = 8'(seg * 2'd3);
                wheel = {8'd0, w3, 8'd255 - w3};
            end
            else
            begin
                seg = w - 8'd170;
                w3  = 8'(seg * 2'd3);
                wheel = {w3, 8'd255 - w3, 8'd0};
            end
        end
    endfunction

endpackage

[src/lseg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lseg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/lseg_recip_div.sv]
// Bit-serial restoring divider that forms 256 / n and 256 mod n, one bit a cycle.
module lseg_recip_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [lseg_pkg::CNT_W-1:0] divisor,
    output lseg_pkg::div_res_t     res
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [3:0]                  cnt_reg;
    logic [8:0]                  quot_reg;
    logic [lseg_pkg::CNT_W-1:0]  rem_reg;
    logic [lseg_pkg::CNT_W-1:0]  div_reg;
    logic [lseg_pkg::CNT_W:0]    trial;
    logic                        ge;

    assign trial = {rem_reg, quot_reg[8]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd8;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= 9'd256;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[7:0], ge};
            rem_reg  <= ge ? lseg_pkg::CNT_W'(trial - {1'b0, div_reg})
                           : lseg_pkg::CNT_W'(trial);
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.quot = quot_reg[7:0];
    assign res.rem  = rem_reg;

endmodule

[src/led_strip_effect_generator_core.sv]
// Top level of the LED strip effect generator: sequencer, frame buffer and pixel unit.
//
// Usage: write the used LED count on the cfg channel (one beat, cfg_data, reset 64;
// zero counts as one, values above MAX_PIXELS saturate). Each beat on the in channel
// is one frame request: op selects the effect, red/green/blue the effect colour and
// restart clears the step counter first. The block then sends one beat per pixel on
// the out channel, pixel_index 0 up to count-1, with last set on the final pixel.
// Between an accepted request and the first pixel, the bit-serial divider forms
// 256 / count for the rainbow cycle spacing. After that one pixel leaves per cycle
// while the receiver takes them; the shared colour unit and the single frame buffer
// read port set that pace.
// in_ready is high only while no frame is being generated; the next request can be
// taken while the last pixels still drain from the output stages.
// A stalled receiver holds the output register, which stops the read pipeline and
// the pixel sequencer until the beat is taken; nothing is dropped.
// Reset clears the step counter, the chase phase and all frame buffer valid bits,
// so every pixel reads as black; the pixel count returns to 64.
`include "led_strip_effect_generator_core_defines.svh"

module led_strip_effect_generator_core #(
    parameter int MAX_PIXELS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pixel_index,
    output logic [23:0] pixel_colour,
    output logic        last
);

    localparam int IDX_W = $clog2(MAX_PIXELS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg;
    logic [lseg_pkg::CNT_W-1:0]    pixel_count_reg;
    logic [2:0]                    op_reg;
    logic [lseg_pkg::COLOUR_W-1:0] colour_reg;
    logic [lseg_pkg::CNT_W-1:0]    n_reg;
    logic [lseg_pkg::STEP_W-1:0]   step_reg;
    logic [1:0]                    phase_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [1:0]                    mod3_reg;
    logic [lseg_pkg::STEP_W-1:0]   q_reg;
    logic [lseg_pkg::CNT_W-1:0]    acc_reg;
    logic [lseg_pkg::STEP_W-1:0]   quo_reg;
    logic [lseg_pkg::CNT_W-1:0]    rmd_reg;
    logic [MAX_PIXELS-1:0]         valid_reg;

    logic                          p1_valid_reg;
    logic [IDX_W-1:0]              p1_idx_reg;
    logic                          p1_last_reg;
    logic                          p1_upd_reg;
    logic                          p1_vld_reg;
    logic [lseg_pkg::COLOUR_W-1:0] p1_col_reg;

    logic                          out_valid_reg;
    logic [5:0]                    out_idx_reg;
    logic [lseg_pkg::COLOUR_W-1:0] out_col_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic [lseg_pkg::CNT_W-1:0]    n_calc;
    logic                          clear_all;
    logic                          p1_move;
    logic                          issue;
    logic                          last_issue;
    logic [7:0]                    wheel_pos;
    logic [lseg_pkg::COLOUR_W-1:0] pix_col;
    logic                          pix_upd;
    logic [lseg_pkg::CNT_W:0]      acc_sum;
    logic                          acc_wrap;
    logic                          step_adv;
    logic                          phase_adv;
    logic [lseg_pkg::COLOUR_W-1:0] ram_rdata;
    lseg_pkg::div_res_t            div_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    // Used pixel count: zero counts as one, anything above the buffer saturates.
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            n_calc = lseg_pkg::CNT_W'(1);
        end
        else if (pixel_count_reg > lseg_pkg::CNT_W'(MAX_PIXELS))
        begin
            n_calc = lseg_pkg::CNT_W'(MAX_PIXELS);
        end
        else
        begin
            n_calc = pixel_count_reg;
        end
    end

    // Blank and both chase effects wipe the whole buffer, including unused pixels.
    assign clear_all = (op == lseg_pkg::OP_BLANK) || (op == lseg_pkg::OP_CHASE) ||
                       (op == lseg_pkg::OP_CHASE_RB);

    lseg_recip_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .divisor (n_calc),
        .res     (div_res)
    );

    // The read pipeline advances when the output register is free or being taken.
    assign p1_move    = p1_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = (state_reg == ST_EMIT) && (!p1_valid_reg || p1_move);
    assign last_issue = (lseg_pkg::CNT_W'(idx_reg) == n_reg - lseg_pkg::CNT_W'(1));

    // Shared pixel colour unit: picks the wheel position for the effect and decides
    // whether the current pixel gets a new value this frame.
    always_comb
    begin
        case (op_reg)
            lseg_pkg::OP_CYCLE:
            begin
                wheel_pos = q_reg + step_reg;
            end
            lseg_pkg::OP_CHASE_RB:
            begin
                wheel_pos = (step_reg == 8'd255) ? 8'd0 : step_reg;
            end
            default:
            begin
                wheel_pos = 8'(idx_reg) + step_reg;
            end
        endcase

        if ((op_reg == lseg_pkg::OP_WIPE) || (op_reg == lseg_pkg::OP_CHASE))
        begin
            pix_col = colour_reg;
        end
        else
        begin
            pix_col = lseg_pkg::wheel(wheel_pos);
        end

        case (op_reg)
            lseg_pkg::OP_WIPE:
            begin
                pix_upd = (8'(idx_reg) == step_reg);
            end
            lseg_pkg::OP_RAINBOW, lseg_pkg::OP_CYCLE:
            begin
                pix_upd = 1'b1;
            end
            lseg_pkg::OP_CHASE, lseg_pkg::OP_CHASE_RB:
            begin
                pix_upd = (mod3_reg == phase_reg);
            end
            default:
            begin
                pix_upd = 1'b0;
            end
        endcase
    end

    // Running i*256/n: add the quotient each pixel and carry when the remainder wraps.
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, rmd_reg};
    assign acc_wrap = acc_sum >= {1'b0, n_reg};

    assign step_adv = ((op_reg == lseg_pkg::OP_WIPE) && (step_reg < 8'(n_reg))) ||
                      (op_reg == lseg_pkg::OP_RAINBOW) || (op_reg == lseg_pkg::OP_CYCLE) ||
                      (op_reg == lseg_pkg::OP_CHASE_RB);
    assign phase_adv = (op_reg == lseg_pkg::OP_CHASE) || (op_reg == lseg_pkg::OP_CHASE_RB);

    lseg_ram #(
        .WIDTH (lseg_pkg::COLOUR_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (issue && pix_upd),
        .waddr (idx_reg),
        .wdata (pix_col),
        .re    (issue),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pixel_count_reg <= lseg_pkg::CNT_W'(64);
            step_reg        <= '0;
            phase_reg       <= 2'd0;
            valid_reg       <= '0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pixel_count_reg <= cfg_data;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DIV;
                        if (restart)
                        begin
                            step_reg <= '0;
                        end
                        if (clear_all)
                        begin
                            valid_reg <= '0;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        if (pix_upd)
                        begin
                            valid_reg[idx_reg] <= 1'b1;
                        end
                        if (last_issue)
                        begin
                            state_reg <= ST_IDLE;
                            if (step_adv)
                            begin
                                step_reg <= step_reg + 8'd1;
                            end
                            if (phase_adv)
                            begin
                                phase_reg <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame context, pixel counters and pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            colour_reg <= {red, green, blue};
            n_reg      <= n_calc;
        end
        if (div_res.done)
        begin
            quo_reg  <= div_res.quot;
            rmd_reg  <= div_res.rem;
            idx_reg  <= '0;
            mod3_reg <= 2'd0;
            q_reg    <= '0;
            acc_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg  <= idx_reg + IDX_W'(1);
            mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            if (acc_wrap)
            begin
                acc_reg <= lseg_pkg::CNT_W'(acc_sum - {1'b0, n_reg});
                q_reg   <= q_reg + quo_reg + 8'd1;
            end
            else
            begin
                acc_reg <= lseg_pkg::CNT_W'(acc_sum);
                q_reg   <= q_reg + quo_reg;
            end
        end
        if (issue)
        begin
            p1_idx_reg  <= idx_reg;
            p1_last_reg <= last_issue;
            p1_upd_reg  <= pix_upd;
            p1_vld_reg  <= valid_reg[idx_reg];
            p1_col_reg  <= pix_col;
        end
        if (p1_move)
        begin
            out_idx_reg  <= 6'(p1_idx_reg);
            out_last_reg <= p1_last_reg;
            if (p1_upd_reg)
            begin
                out_col_reg <= p1_col_reg;
            end
            else if (p1_vld_reg)
            begin
                out_col_reg <= ram_rdata;
            end
            else
            begin
                out_col_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = out_idx_reg;
    assign pixel_colour = out_col_reg;
    assign last         = out_last_reg;

    // The divider reports a result only while the sequencer waits for it.
    `LSEG_ASSERT(a_div_done_in_div, !div_res.done || (state_reg == ST_DIV))
    // Pixels are only sequenced once the divider has finished.
    `LSEG_ASSERT(a_emit_div_idle, (state_reg != ST_EMIT) || !div_res.busy)
    // Issuing the final pixel returns the sequencer to idle.
    `LSEG_ASSERT_NEXT(a_last_to_idle, issue && last_issue, state_reg == ST_IDLE)
    // A new pixel read never overwrites a stalled read result.
    `LSEG_ASSERT_NEXT(a_p1_hold, p1_valid_reg && !p1_move, p1_valid_reg)

endmodule

[bench/led_frame_checker.sv]
// Frame checker for the LED strip effect generator: predicts each frame and compares pixels.
`timescale 1ns / 100ps

module led_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        restart,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  pixel_index,
    input  logic [23:0] pixel_colour,
    input  logic        last,
    output int          mismatches,
    output int          pending
);

    localparam int STRIP_MAX  = 64;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [5:0]  idx;
        logic [23:0] colour;
        logic        tail;
    } pixel_t;

    logic [23:0] strip_buf [STRIP_MAX];
    logic [7:0]  step_ctr;
    logic [1:0]  chase_ph;
    logic [6:0]  strip_len;
    pixel_t      pixel_q [$];
    int          fault_cnt;

    // Three-segment wheel: red fades to green, green to blue, blue back to red.
    function automatic logic [23:0] colour_wheel(input logic [7:0] pos);
        int wv;
        wv = 255 - int'(pos);
        if (wv < 85)
            return {8'(255 - wv * 3), 8'h00, 8'(wv * 3)};
        if (wv < 170)
        begin
            wv = wv - 85;
            return {8'h00, 8'(wv * 3), 8'(255 - wv * 3)};
        end
        wv = wv - 170;
        return {8'(wv * 3), 8'(255 - wv * 3), 8'h00};
    endfunction

    task automatic chase_fill(input int n, input logic [23:0] tint);
        int k;
        for (k = 0; k < STRIP_MAX; k++)
            strip_buf[k] = 24'h0;
        for (k = 0; k < n; k += 3)
        begin
            if (k + int'(chase_ph) < n)
                strip_buf[k + int'(chase_ph)] = tint;
        end
        chase_ph = (chase_ph >= 2'd2) ? 2'd0 : chase_ph + 2'd1;
    endtask

    // Applies one frame request to the predicted strip and queues the pixels it emits.
    task automatic render_frame(input logic [2:0] f_op, input logic [23:0] tint,
                                input logic clr);
        int     n;
        int     k;
        pixel_t pix;
        n = (strip_len == 7'd0) ? 1 : (int'(strip_len) > STRIP_MAX) ? STRIP_MAX
                                                                      : int'(strip_len);
        if (clr)
            step_ctr = 8'd0;
        case (f_op)
            lseg_pkg::OP_BLANK:
            begin
                for (k = 0; k < STRIP_MAX; k++)
                    strip_buf[k] = 24'h0;
            end
            lseg_pkg::OP_WIPE:
            begin
                if (int'(step_ctr) < n)
                begin
                    strip_buf[step_ctr[5:0]] = tint;
                    step_ctr = step_ctr + 8'd1;
                end
            end
            lseg_pkg::OP_RAINBOW:
            begin
                for (k = 0; k < n; k++)
                    strip_buf[k] = colour_wheel(8'(k + int'(step_ctr)));
                step_ctr = step_ctr + 8'd1;
            end
            lseg_pkg::OP_CYCLE:
            begin
                for (k = 0; k < n; k++)
                    strip_buf[k] = colour_wheel(8'((k * 256) / n + int'(step_ctr)));
                step_ctr = step_ctr + 8'd1;
            end
            lseg_pkg::OP_CHASE:
                chase_fill(n, tint);
            lseg_pkg::OP_CHASE_RB:
            begin
                chase_fill(n, colour_wheel(8'(int'(step_ctr) % 255)));
                step_ctr = step_ctr + 8'd1;
            end
            default:
            begin
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            pix.idx    = 6'(k);
            pix.colour = strip_buf[k];
            pix.tail   = (k == n - 1);
            pixel_q.push_back(pix);
        end
    endtask

    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (pixel_q.size() == 0)
        begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
                $display("%0t: unexpected pixel beat idx %0d colour %06h last %0b",
                         $realtime, got.idx, got.colour, got.tail);
        end
        else
        begin
            want = pixel_q.pop_front();
            if (want.idx !== got.idx || want.colour !== got.colour || want.tail !== got.tail)
            begin
                fault_cnt++;
                if (fault_cnt <= REPORT_MAX)
                    $display("%0t: expected %0d/%06h/%0b, got %0d/%06h/%0b",
                             $realtime, want.idx, want.colour, want.tail,
                             got.idx, got.colour, got.tail);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STRIP_MAX; k++)
                strip_buf[k] = 24'h0;
            step_ctr   = 8'd0;
            chase_ph   = 2'd0;
            strip_len  = 7'd64;
            fault_cnt  = 0;
            pixel_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                strip_len = cfg_data;
            if (in_valid && in_ready)
                render_frame(op, {red, green, blue}, restart);
            if (out_valid && out_ready)
                check_pixel({pixel_index, pixel_colour, last});
            mismatches <= fault_cnt;
            pending    <= pixel_q.size();
        end
    end

endmodule

[bench/tb.sv]
// Testbench top for the LED strip effect generator: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module tb;

    // Op code seven has no effect of its own; the block must treat it as a no-op.
    localparam logic [2:0] OP_SPARE = 3'd7;

    // A receiver hold lasts this long; the block must fill up and stall its input.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any beat on any channel before the run is declared hung. The
    // longest honest quiet stretch is the receiver hold plus a short pipeline latency.
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 40;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data     = 7'd0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [2:0]  op           = lseg_pkg::OP_NOP;
    logic [7:0]  red          = 8'h00;
    logic [7:0]  green        = 8'h00;
    logic [7:0]  blue         = 8'h00;
    logic        restart      = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [5:0]  pixel_index;
    logic [23:0] pixel_colour;
    logic        last;

    int          mismatches;
    int          pending;
    int          quiet_cycles = 0;
    int          hold_left    = 0;
    logic        hold_start   = 1'b0;
    logic        calm         = 1'b0;

    // Pixel counts for the random phases: extremes, the zero and oversize cases, and
    // values that together set every bit of the count register both ways.
    logic [6:0] phase_len [PHASES] = '{7'd64, 7'd5, 7'd1, 7'd40, 7'd2,
                                       7'd127, 7'd3, 7'd0, 7'd17, 7'd64};

    always #1 clk = ~clk;

    led_strip_effect_generator_core #(
        .MAX_PIXELS(64)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_index  (pixel_index),
        .pixel_colour (pixel_colour),
        .last         (last)
    );

    led_frame_checker frame_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_index  (pixel_index),
        .pixel_colour (pixel_colour),
        .last         (last),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Pixel receiver. Outside a hold it drops ready at random, about seven times in a hundred,
    // and never while the calm stretch is on. A hold request parks ready low for a
    // fixed stretch, counted here, so the output register and the whole pixel
    // pipeline back up while the sender keeps offering frame requests.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 7);
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Colour level with the extremes weighted up, so fully dark and fully lit
    // components turn up often next to random ones.
    function automatic logic [7:0] rand_level();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    // Offers one frame request and returns at the edge where it is accepted. Valid
    // stays high on return, so back-to-back requests never lower and raise it in the
    // same step; a random gap lowers it first and waits before raising it again.
    task automatic push_frame(input logic [2:0] f_op, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic clr);
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= f_op;
        red      <= r;
        green    <= g;
        blue     <= b;
        restart  <= clr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Pauses the sender until every predicted pixel has come out. Every request emits
    // at least one pixel, so an empty expectation list means the block is idle.
    task automatic drain_frames();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Writes the pixel count; only called with the block idle.
    task automatic write_strip_len(input logic [6:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random frame request, weighted toward the effects that move the step
    // counter so that it wanders across its whole range, with a rare restart.
    task automatic push_random_frame();
        int          pick;
        logic [2:0]  f_op;
        pick = $urandom_range(99);
        if (pick < 10)
            f_op = lseg_pkg::OP_BLANK;
        else if (pick < 30)
            f_op = lseg_pkg::OP_WIPE;
        else if (pick < 45)
            f_op = lseg_pkg::OP_RAINBOW;
        else if (pick < 60)
            f_op = lseg_pkg::OP_CYCLE;
        else if (pick < 75)
            f_op = lseg_pkg::OP_CHASE;
        else if (pick < 88)
            f_op = lseg_pkg::OP_CHASE_RB;
        else if (pick < 94)
            f_op = lseg_pkg::OP_NOP;
        else
            f_op = OP_SPARE;
        push_frame(f_op, rand_level(), rand_level(), rand_level(),
                   $urandom_range(49) == 0);
    endtask

    initial
    begin
        int ph;
        int sent;
        int used;
        int k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames on the full 64-pixel strip left by reset. The first wipe beat
        // restarts the step and both wipes fill the first pixels; four chases walk the phase
        // through 0, 1, 2 and back to 0, and with phases 1 and 2 the last chase
        // positions fall past the end of the strip and must be dropped.
        push_frame(lseg_pkg::OP_BLANK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(lseg_pkg::OP_WIPE, 8'hff, 8'hff, 8'hff, 1'b1);
        push_frame(lseg_pkg::OP_WIPE, 8'ha5, 8'h5a, 8'h0f, 1'b0);
        push_frame(lseg_pkg::OP_RAINBOW, 8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(lseg_pkg::OP_CYCLE, 8'hff, 8'hff, 8'hff, 1'b0);
        push_frame(lseg_pkg::OP_CHASE, 8'hff, 8'h00, 8'h80, 1'b0);
        push_frame(lseg_pkg::OP_CHASE, 8'h01, 8'hfe, 8'h7f, 1'b0);
        push_frame(lseg_pkg::OP_CHASE, 8'h5a, 8'ha5, 8'hf0, 1'b0);
        push_frame(lseg_pkg::OP_CHASE, 8'hff, 8'hff, 8'hff, 1'b0);
        push_frame(lseg_pkg::OP_CHASE_RB, 8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(lseg_pkg::OP_NOP, 8'hff, 8'hff, 8'hff, 1'b0);
        push_frame(OP_SPARE, 8'h12, 8'h34, 8'h56, 1'b0);

        // Three pixels: a wipe one step past the end must leave the strip alone, and
        // the pixels beyond the count keep their old colours without being emitted.
        drain_frames();
        write_strip_len(7'd3);
        push_frame(lseg_pkg::OP_WIPE, 8'h11, 8'h22, 8'h33, 1'b1);
        push_frame(lseg_pkg::OP_WIPE, 8'h44, 8'h55, 8'h66, 1'b0);
        push_frame(lseg_pkg::OP_WIPE, 8'h77, 8'h88, 8'h99, 1'b0);
        push_frame(lseg_pkg::OP_WIPE, 8'hff, 8'hff, 8'hff, 1'b0);
        push_frame(lseg_pkg::OP_CHASE, 8'hc3, 8'h3c, 8'h81, 1'b0);
        push_frame(lseg_pkg::OP_CYCLE, 8'h00, 8'h00, 8'h00, 1'b0);

        // A count of zero must behave as a single pixel.
        drain_frames();
        write_strip_len(7'd0);
        push_frame(lseg_pkg::OP_RAINBOW, 8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(lseg_pkg::OP_WIPE, 8'hee, 8'hdd, 8'hcc, 1'b1);

        // An oversize count must saturate at the full strip.
        drain_frames();
        write_strip_len(7'd127);
        push_frame(lseg_pkg::OP_CYCLE, 8'h00, 8'h00, 8'h00, 1'b0);
        push_frame(lseg_pkg::OP_CHASE_RB, 8'h00, 8'h00, 8'h00, 1'b0);

        // Random phases, each on its own pixel count written while the block is idle.
        // Phase 3 runs with no idling on either side; phase 5 opens with a long
        // receiver hold while the sender keeps pushing full-strip frames.
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_frames();
            write_strip_len(phase_len[ph]);
            calm <= (ph == 3);
            if (ph == 5)
            begin
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            used = (phase_len[ph] == 7'd0) ? 1 : (phase_len[ph] > 7'd64) ? 64
                                                                          : phase_len[ph];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // On short strips, often run a whole wipe sweep: one wipe per pixel, the first
                // with restart, then one more that must fall off the end.
                if (used <= 8 && $urandom_range(3) == 0)
                begin
                    push_frame(lseg_pkg::OP_WIPE, rand_level(), rand_level(),
                               rand_level(), 1'b1);
                    for (k = 0; k < used; k++)
                        push_frame(lseg_pkg::OP_WIPE, rand_level(), rand_level(),
                                   rand_level(), 1'b0);
                    sent += used + 1;
                end
                else
                begin
                    push_random_frame();
                    sent++;
                end
            end
        end

        // Let the last frame leave, then give the pipeline its latency once more so a
        // stray extra beat would still be caught.
        drain_frames();
        calm <= 1'b0;
        repeat (40) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lseg_pkg.sv
src/lseg_ram.sv
src/lseg_recip_div.sv
src/led_strip_effect_generator_core.sv
bench/led_frame_checker.sv
bench/tb.sv
